// ----- rtl/legv8_ex_pkg.sv -----
package legv8_ex_pkg;

  localparam int MEM_BYTES  = 16384;
  localparam int MEM_AW     = $clog2(MEM_BYTES);
  localparam int REG_COUNT  = 32;
  localparam int RF_AW      = $clog2(REG_COUNT);
  localparam int PROG_DEPTH = 1024;
  localparam int IDX_W      = $clog2(PROG_DEPTH);
  localparam int NXT_W      = IDX_W + 1;
  localparam logic [RF_AW-1:0] LINK_REG = RF_AW'(30);

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,  OP_ADDS  = 5'd1,  OP_ADDI  = 5'd2,  OP_ADDIS = 5'd3,
    OP_SUB   = 5'd4,  OP_SUBS  = 5'd5,  OP_SUBI  = 5'd6,  OP_SUBIS = 5'd7,
    OP_AND   = 5'd8,  OP_ANDS  = 5'd9,  OP_ANDI  = 5'd10, OP_ANDIS = 5'd11,
    OP_ORR   = 5'd12, OP_ORRI  = 5'd13, OP_EOR   = 5'd14, OP_EORI  = 5'd15,
    OP_LSL   = 5'd16, OP_LSR   = 5'd17, OP_LDUR  = 5'd18, OP_LDURW = 5'd19,
    OP_LDURH = 5'd20, OP_LDURB = 5'd21, OP_STUR  = 5'd22, OP_STURW = 5'd23,
    OP_STURH = 5'd24, OP_STURB = 5'd25, OP_B     = 5'd26, OP_BL    = 5'd27,
    OP_BR    = 5'd28, OP_BCOND = 5'd29, OP_CBZ   = 5'd30, OP_CBNZ  = 5'd31
  } mode_t;

  localparam logic [3:0] CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_HS = 4'd2,  CC_LO = 4'd3;
  localparam logic [3:0] CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7;
  localparam logic [3:0] CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11;
  localparam logic [3:0] CC_GT = 4'd12, CC_LE = 4'd13;

  typedef enum logic [1:0] {
    RS_RN, RS_RM, RS_RD, RS_LR
  } rsel_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RA, S_RB, S_RD, S_RL, S_EXEC, S_LD, S_ST, S_FIN
  } st_t;

  typedef struct packed {
    logic  accept;
    rsel_t rf_sel;
    logic  cap_a;
    logic  cap_b;
    logic  cap_d;
    logic  exec;
    logic  ld_step;
    logic  st_step;
    logic  clr_step;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic go_ld;
    logic go_st;
    logic ld_done;
    logic st_done;
  } sts_t;

endpackage

// ----- rtl/legv8_ex_ctrl.sv -----
module legv8_ex_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_stall,
  output logic               out_valid,
  input  legv8_ex_pkg::sts_t sts,
  output legv8_ex_pkg::cmd_t cmd
);

  legv8_ex_pkg::st_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !(out_valid_r && out_stall);
  assign in_stall  = (state_r != legv8_ex_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= legv8_ex_pkg::S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      legv8_ex_pkg::S_CLR:  if (sts.clr_done) state_nxt = legv8_ex_pkg::S_IDLE;
      legv8_ex_pkg::S_IDLE: if (in_valid) state_nxt = legv8_ex_pkg::S_RA;
      legv8_ex_pkg::S_RA:   state_nxt = legv8_ex_pkg::S_RB;
      legv8_ex_pkg::S_RB:   state_nxt = legv8_ex_pkg::S_RD;
      legv8_ex_pkg::S_RD:   state_nxt = legv8_ex_pkg::S_RL;
      legv8_ex_pkg::S_RL:   state_nxt = legv8_ex_pkg::S_EXEC;
      legv8_ex_pkg::S_EXEC: begin
        if (sts.go_ld)      state_nxt = legv8_ex_pkg::S_LD;
        else if (sts.go_st) state_nxt = legv8_ex_pkg::S_ST;
        else                state_nxt = legv8_ex_pkg::S_FIN;
      end
      legv8_ex_pkg::S_LD:   if (sts.ld_done) state_nxt = legv8_ex_pkg::S_FIN;
      legv8_ex_pkg::S_ST:   if (sts.st_done) state_nxt = legv8_ex_pkg::S_FIN;
      legv8_ex_pkg::S_FIN:  if (out_free) state_nxt = legv8_ex_pkg::S_IDLE;
      default:              state_nxt = legv8_ex_pkg::S_CLR;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.rf_sel = legv8_ex_pkg::RS_RN;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      legv8_ex_pkg::S_CLR:  cmd.clr_step = 1'b1;
      legv8_ex_pkg::S_IDLE: cmd.accept = in_valid;
      legv8_ex_pkg::S_RA:   cmd.rf_sel = legv8_ex_pkg::RS_RN;
      legv8_ex_pkg::S_RB: begin
        cmd.rf_sel = legv8_ex_pkg::RS_RM;
        cmd.cap_a  = 1'b1;
      end
      legv8_ex_pkg::S_RD: begin
        cmd.rf_sel = legv8_ex_pkg::RS_RD;
        cmd.cap_b  = 1'b1;
      end
      legv8_ex_pkg::S_RL: begin
        cmd.rf_sel = legv8_ex_pkg::RS_LR;
        cmd.cap_d  = 1'b1;
      end
      legv8_ex_pkg::S_EXEC: cmd.exec = 1'b1;
      legv8_ex_pkg::S_LD:   cmd.ld_step = 1'b1;
      legv8_ex_pkg::S_ST:   cmd.st_step = 1'b1;
      legv8_ex_pkg::S_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/legv8_ex_dp.sv -----
module legv8_ex_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  legv8_ex_pkg::cmd_t cmd,
  output legv8_ex_pkg::sts_t sts,
  input  logic [4:0]         in_mode,
  input  logic [3:0]         in_branch_condition,
  input  logic [4:0]         in_dest_reg,
  input  logic [4:0]         in_first_source_reg,
  input  logic [4:0]         in_second_source_reg,
  input  logic [11:0]        in_immediate,
  input  logic [9:0]         in_target_index,
  input  logic [9:0]         in_current_index,
  output logic [10:0]        out_next_index,
  output logic               out_branch_taken,
  output logic               out_reg_written,
  output logic [63:0]        out_written_value,
  output logic [3:0]         out_flags_out,
  output logic               out_address_fault
);

  localparam int AW = legv8_ex_pkg::MEM_AW;
  localparam int RW = legv8_ex_pkg::RF_AW;
  localparam int NW = legv8_ex_pkg::NXT_W;
  localparam int IW = legv8_ex_pkg::IDX_W;

  // latched instruction
  legv8_ex_pkg::mode_t mode_r;
  logic [3:0]    cond_r;
  logic [RW-1:0] rd_r, rn_r, rm_r;
  logic [11:0]   imm_r;
  logic [IW-1:0] tgt_r, cur_r;

  // register file with per-entry valid bits
  logic [63:0]           rf [legv8_ex_pkg::REG_COUNT];
  logic [legv8_ex_pkg::REG_COUNT-1:0] rf_vld_r;
  logic [63:0]           rf_q_r;
  logic [RW-1:0]         rf_addr;
  logic [63:0]           a_r, b_r, d_r;

  logic [3:0] flags_r;

  // step result
  logic [63:0]   res_val_r;
  logic          res_wr_r, res_rep_r;
  logic [RW-1:0] res_waddr_r;
  logic [NW-1:0] res_next_r;
  logic          res_taken_r, res_fault_r;
  logic [3:0]    res_flags_r;

  // memory
  logic [7:0]    mem [legv8_ex_pkg::MEM_BYTES];
  logic [7:0]    mem_q_r;
  logic [AW-1:0] base_r, clr_cnt_r, mem_addr;
  logic [3:0]    cnt_r, size_r;
  logic          mem_we;
  logic [7:0]    mem_wd;
  logic [2:0]    ld_bi;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= legv8_ex_pkg::mode_t'(in_mode);
      cond_r <= in_branch_condition;
      rd_r   <= in_dest_reg;
      rn_r   <= in_first_source_reg;
      rm_r   <= in_second_source_reg;
      imm_r  <= in_immediate;
      tgt_r  <= in_target_index;
      cur_r  <= in_current_index;
    end
  end

  always_comb begin
    case (cmd.rf_sel)
      legv8_ex_pkg::RS_RN: rf_addr = rn_r;
      legv8_ex_pkg::RS_RM: rf_addr = rm_r;
      legv8_ex_pkg::RS_RD: rf_addr = rd_r;
      default:             rf_addr = legv8_ex_pkg::LINK_REG;
    endcase
  end

  always_ff @(posedge clk) begin
    rf_q_r <= rf_vld_r[rf_addr] ? rf[rf_addr] : 64'd0;
    if (cmd.finish && res_wr_r) rf[res_waddr_r] <= res_val_r;
    if (cmd.cap_a) a_r <= rf_q_r;
    if (cmd.cap_b) b_r <= rf_q_r;
    if (cmd.cap_d) d_r <= rf_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      flags_r  <= 4'd0;
    end else if (cmd.finish) begin
      if (res_wr_r) rf_vld_r[res_waddr_r] <= 1'b1;
      flags_r <= res_flags_r;
    end
  end

  // execute
  logic [63:0] alu_val, lr;
  logic [64:0] add_w, sub_w;
  logic [3:0]  alu_flags;
  logic        n_f, z_f, v_f, c_f, cond_ok, go;
  logic [63:0] maddr, mlim;
  logic [4:0]  moff;
  logic [3:0]  msize;
  logic        mfault;

  assign lr    = rf_q_r;
  always_comb begin
    logic [63:0] o;
    o = mode_r[1] ? {52'd0, imm_r} : b_r;
    add_w = {1'b0, a_r} + {1'b0, o};
    sub_w = {1'b0, a_r} - {1'b0, o};
    alu_flags = flags_r;
    alu_val = 64'd0;
    case (mode_r[3:2])
      2'd0: begin
        alu_val = add_w[63:0];
        alu_flags = {alu_val[63], alu_val == 64'd0,
                     (~(a_r[63] ^ o[63])) & (a_r[63] ^ alu_val[63]), add_w[64]};
      end
      2'd1: begin
        alu_val = sub_w[63:0];
        alu_flags = {alu_val[63], alu_val == 64'd0,
                     (a_r[63] ^ o[63]) & (a_r[63] ^ alu_val[63]), ~sub_w[64]};
      end
      default: begin
        alu_val = a_r & o;
        alu_flags = {alu_val[63], alu_val == 64'd0, 2'b00};
      end
    endcase
    if (!mode_r[0]) alu_flags = flags_r;
  end

  always_comb begin
    {n_f, z_f, v_f, c_f} = flags_r;
    case (cond_r)
      legv8_ex_pkg::CC_EQ: cond_ok = z_f;
      legv8_ex_pkg::CC_NE: cond_ok = !z_f;
      legv8_ex_pkg::CC_HS: cond_ok = c_f;
      legv8_ex_pkg::CC_LO: cond_ok = !c_f;
      legv8_ex_pkg::CC_MI: cond_ok = n_f;
      legv8_ex_pkg::CC_PL: cond_ok = !n_f;
      legv8_ex_pkg::CC_VS: cond_ok = v_f;
      legv8_ex_pkg::CC_VC: cond_ok = !v_f;
      legv8_ex_pkg::CC_HI: cond_ok = c_f && !z_f;
      legv8_ex_pkg::CC_LS: cond_ok = !(c_f && !z_f);
      legv8_ex_pkg::CC_GE: cond_ok = n_f == v_f;
      legv8_ex_pkg::CC_LT: cond_ok = n_f != v_f;
      legv8_ex_pkg::CC_GT: cond_ok = !z_f && n_f == v_f;
      legv8_ex_pkg::CC_LE: cond_ok = !(!z_f && n_f == v_f);
      default:             cond_ok = 1'b0;
    endcase
  end

  // access size: 8, 4, 2 or 1 bytes
  assign moff   = mode_r - legv8_ex_pkg::OP_LDUR;
  assign msize  = 4'd8 >> moff[1:0];
  assign maddr  = a_r + {52'd0, imm_r};
  assign mlim   = 64'(legv8_ex_pkg::MEM_BYTES) - {60'd0, msize};
  assign mfault = maddr > mlim;

  logic is_alu, is_log, is_mem;
  assign is_alu = mode_r <= legv8_ex_pkg::OP_ANDIS;
  assign is_log = !is_alu && mode_r <= legv8_ex_pkg::OP_LSR;
  assign is_mem = !is_alu && !is_log && mode_r <= legv8_ex_pkg::OP_STURB;

  assign sts.go_ld   = cmd.exec && is_mem && !mfault && mode_r <= legv8_ex_pkg::OP_LDURB;
  assign sts.go_st   = cmd.exec && is_mem && !mfault && mode_r >= legv8_ex_pkg::OP_STUR;
  assign sts.ld_done = cnt_r == size_r;
  assign sts.st_done = cnt_r == size_r - 4'd1;
  assign sts.clr_done = clr_cnt_r == AW'(legv8_ex_pkg::MEM_BYTES - 1);

  always_comb begin
    case (mode_r)
      legv8_ex_pkg::OP_B, legv8_ex_pkg::OP_BL: go = 1'b1;
      legv8_ex_pkg::OP_BCOND: go = cond_ok;
      legv8_ex_pkg::OP_CBZ:   go = d_r == 64'd0;
      legv8_ex_pkg::OP_CBNZ:  go = d_r != 64'd0;
      default:                go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_val_r   <= 64'd0;
      res_wr_r    <= 1'b0;
      res_rep_r   <= 1'b0;
      res_waddr_r <= rd_r;
      res_next_r  <= {1'b0, cur_r};
      res_taken_r <= 1'b0;
      res_fault_r <= 1'b0;
      res_flags_r <= flags_r;
      base_r      <= maddr[AW-1:0];
      size_r      <= msize;
      cnt_r       <= 4'd0;
      if (is_alu) begin
        res_val_r   <= alu_val;
        res_wr_r    <= 1'b1;
        res_rep_r   <= 1'b1;
        res_flags_r <= alu_flags;
      end else if (is_log) begin
        res_wr_r  <= 1'b1;
        res_rep_r <= 1'b1;
        case (mode_r)
          legv8_ex_pkg::OP_ORR:  res_val_r <= a_r | b_r;
          legv8_ex_pkg::OP_ORRI: res_val_r <= a_r | {52'd0, imm_r};
          legv8_ex_pkg::OP_EOR:  res_val_r <= a_r ^ b_r;
          legv8_ex_pkg::OP_EORI: res_val_r <= a_r ^ {52'd0, imm_r};
          legv8_ex_pkg::OP_LSL:  res_val_r <= a_r << imm_r[5:0];
          default:               res_val_r <= a_r >> imm_r[5:0];
        endcase
      end else if (is_mem) begin
        res_fault_r <= mfault;
        if (!mfault && mode_r <= legv8_ex_pkg::OP_LDURB) begin
          res_wr_r  <= 1'b1;
          res_rep_r <= 1'b1;
        end
      end else begin
        if (mode_r == legv8_ex_pkg::OP_BR) begin
          res_next_r  <= lr[NW-1:0];
          res_taken_r <= 1'b1;
        end else if (go) begin
          res_next_r  <= {1'b0, tgt_r} - NW'(1);
          res_taken_r <= 1'b1;
        end
        if (mode_r == legv8_ex_pkg::OP_BL) begin
          res_val_r   <= {{(64-IW){1'b0}}, cur_r};
          res_wr_r    <= 1'b1;
          res_rep_r   <= 1'b1;
          res_waddr_r <= legv8_ex_pkg::LINK_REG;
        end
      end
    end else if (cmd.ld_step || cmd.st_step) begin
      cnt_r <= cnt_r + 4'd1;
      if (cmd.ld_step && cnt_r != 4'd0) res_val_r[8*ld_bi +: 8] <= mem_q_r;
    end
  end

  // byte memory, one port; cleared by a sweep after reset
  assign ld_bi = cnt_r[2:0] - 3'd1;

  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = 8'd0;
    mem_addr = base_r + AW'(cnt_r[2:0]);
    if (cmd.clr_step) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt_r;
    end else if (cmd.st_step) begin
      mem_we = 1'b1;
      mem_wd = d_r[8*cnt_r[2:0] +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_step && !sts.clr_done) clr_cnt_r <= clr_cnt_r + AW'(1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_next_index    <= res_next_r;
      out_branch_taken  <= res_taken_r;
      out_reg_written   <= res_rep_r;
      out_written_value <= res_rep_r ? res_val_r : 64'd0;
      out_flags_out     <= res_flags_r;
      out_address_fault <= res_fault_r;
    end
  end

endmodule

// ----- rtl/legv8_instruction_execute.sv -----
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall  | decoded instruction, one per beat
// out_    | output    | out_valid / out_stall| next index, write-back and flags, one per beat
//
// an instruction is accepted, reads rn, rm, rd and the link register, executes, then for
// stores writes one byte per memory step and for loads one step more than its size, and
// finishes; the single-port byte memory and single register-file read port set this order
// after reset a sweep clears the 16384-byte memory, one byte a cycle, with in_stall high
// one result register sits on the output; a stalled result holds the block in its last step
module legv8_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_mode,
  input  logic [3:0]  in_branch_condition,
  input  logic [4:0]  in_dest_reg,
  input  logic [4:0]  in_first_source_reg,
  input  logic [4:0]  in_second_source_reg,
  input  logic [11:0] in_immediate,
  input  logic [9:0]  in_target_index,
  input  logic [9:0]  in_current_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_next_index,
  output logic        out_branch_taken,
  output logic        out_reg_written,
  output logic [63:0] out_written_value,
  output logic [3:0]  out_flags_out,
  output logic        out_address_fault
);

  // commands from the sequencer, status back from the datapath
  legv8_ex_pkg::cmd_t cmd;
  legv8_ex_pkg::sts_t sts;

  legv8_ex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // register file, flags, byte memory and the result register
  legv8_ex_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_mode              (in_mode),
    .in_branch_condition  (in_branch_condition),
    .in_dest_reg          (in_dest_reg),
    .in_first_source_reg  (in_first_source_reg),
    .in_second_source_reg (in_second_source_reg),
    .in_immediate         (in_immediate),
    .in_target_index      (in_target_index),
    .in_current_index     (in_current_index),
    .out_next_index       (out_next_index),
    .out_branch_taken     (out_branch_taken),
    .out_reg_written      (out_reg_written),
    .out_written_value    (out_written_value),
    .out_flags_out        (out_flags_out),
    .out_address_fault    (out_address_fault)
  );

endmodule
